[hdl/ors_pkg.sv]
// shared types and codes for the search rom decision engine
package ors_pkg;

    // item function codes
    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_BIT   = 1'b1
    } t_func;

    // result status codes
    typedef enum logic [2:0] {
        ST_STARTED   = 3'd0,
        ST_BIT_DONE  = 3'd1,
        ST_COMPLETE  = 3'd2,
        ST_NO_PRES   = 3'd3,
        ST_DATA_ERR  = 3'd4,
        ST_NO_PASS   = 3'd5
    } t_status;

    localparam int LINES    = 4;
    localparam int ROM_W    = 64;
    localparam int DISC_W   = 8;
    localparam int NEXT_W   = 7;

    // request item
    typedef struct packed {
        t_func             func;
        logic [DISC_W-1:0] start_discrepancy;
        logic [LINES-1:0]  presence_errors;
        logic [LINES-1:0]  read_bits;
        logic [LINES-1:0]  complement_bits;
    } t_item;

    // result item
    typedef struct packed {
        t_status           status;
        logic [LINES-1:0]  write_bits;
        logic [ROM_W-1:0]  rom_id;
        logic [NEXT_W-1:0] next_discrepancy;
    } t_result;

    // configuration write data
    typedef logic [LINES-1:0] t_cfg;

endpackage

[hdl/ors_stream_if.sv]
// valid/ready channel carrying one payload per request
interface ors_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/ors_in_stage.sv]
// input register stage for bit-pair and start requests
module ors_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ors_stream_if.sink    i_req,
    input  logic          i_take,
    output logic          o_valid,
    output ors_pkg::t_item o_item
);
    import ors_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    // free slot when empty or when the held request moves on this cycle
    assign i_req.ready = !r_valid || i_take;

    // occupancy of the input register
    always_comb begin
        n_valid = r_valid;
        if (i_req.valid && i_req.ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item <= i_req.payload;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hdl/ors_core.sv]
// search state, per-bit direction decision and result register
module ors_core #(
    parameter int ID_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ors_pkg::t_item       i_item,
    input  ors_pkg::t_cfg        i_mask,
    output logic                 o_take,
    ors_stream_if.source         o_res
);
    import ors_pkg::*;

    localparam int BL_W = $clog2(ID_BITS + 1);
    localparam logic [BL_W-1:0] BITS_FULL = BL_W'(ID_BITS);
    localparam logic [BL_W-1:0] BITS_ONE  = BL_W'(1);

    // search state
    logic [ID_BITS-1:0] r_id,     n_id;
    logic [BL_W-1:0]    r_bits,   n_bits;
    logic [BL_W-1:0]    r_found,  n_found;
    logic [DISC_W-1:0]  r_prev,   n_prev;
    logic               r_active, n_active;

    // result register
    logic    r_out_valid, n_out_valid;
    t_result r_out,       n_out;

    logic [LINES-1:0]  rd;
    logic [LINES-1:0]  cp;
    logic [LINES-1:0]  dir;
    logic [DISC_W-1:0] pos_ext;
    logic              disc_one;

    // a request moves on when the result slot is free or being drained
    assign o_take = i_valid && (!r_out_valid || o_res.ready);

    // masked line values and discrepancy choice
    assign rd       = i_item.read_bits & i_mask;
    assign cp       = i_item.complement_bits & i_mask;
    assign pos_ext  = {{(DISC_W - BL_W){1'b0}}, r_bits};
    assign disc_one = (r_prev > pos_ext) || (r_id[0] && (r_prev != pos_ext));

    // next state and result
    always_comb begin
        n_id     = r_id;
        n_bits   = r_bits;
        n_found  = r_found;
        n_prev   = r_prev;
        n_active = r_active;
        n_out    = r_out;
        dir      = rd;
        if (o_take) begin
            n_out = '0;
            case (i_item.func)
                FUNC_START: begin
                    if (|(i_item.presence_errors & i_mask)) begin
                        n_active     = 1'b0;
                        n_out.status = ST_NO_PRES;
                    end else begin
                        n_active     = 1'b1;
                        n_bits       = BITS_FULL;
                        n_found      = '0;
                        n_prev       = i_item.start_discrepancy;
                        n_out.status = ST_STARTED;
                    end
                end
                FUNC_BIT: begin
                    if (!r_active || (r_bits == '0)) begin
                        n_out.status = ST_NO_PASS;
                    end else if ((|cp) && (|rd)) begin
                        n_active     = 1'b0;
                        n_out.status = ST_DATA_ERR;
                    end else begin
                        // both slots low on every masked-in line: take the 1 branch when due
                        if (!(|cp) && !(|rd) && disc_one) begin
                            dir     = i_mask;
                            n_found = r_bits;
                        end
                        n_id             = {(|dir), r_id[ID_BITS-1:1]};
                        n_bits           = r_bits - BITS_ONE;
                        n_out.write_bits = dir;
                        if (r_bits == BITS_ONE) begin
                            n_active               = 1'b0;
                            n_out.status           = ST_COMPLETE;
                            n_out.rom_id           = ROM_W'(n_id);
                            n_out.next_discrepancy = NEXT_W'(n_found);
                        end else begin
                            n_out.status = ST_BIT_DONE;
                        end
                    end
                end
                default: begin
                    n_out.status = ST_NO_PASS;
                end
            endcase
        end
    end

    // result slot occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_take) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id        <= '0;
            r_bits      <= '0;
            r_found     <= '0;
            r_prev      <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_id        <= n_id;
            r_bits      <= n_bits;
            r_found     <= n_found;
            r_prev      <= n_prev;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // a running pass always has positions left
    a_active_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_bits != '0))
        else $error("pass active with no positions left");

    // recorded discrepancy never beyond the id length
    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found <= BITS_FULL)
        else $error("discrepancy position out of range");

    // a finished or failed pass leaves no pass running
    a_end_clears_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out.status == ST_COMPLETE) || (r_out.status == ST_DATA_ERR)
            || (r_out.status == ST_NO_PRES))) |-> !r_active)
        else $error("pass still active after it ended");

    // a started pass holds the full count until a bit request is taken
    a_start_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == ST_STARTED) && !o_take) |-> (r_bits == BITS_FULL))
        else $error("start did not load the full count");

    // a stalled result leaves the search state alone
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> ($stable(r_bits) && $stable(r_active)))
        else $error("state moved under a stalled result");

endmodule

[hdl/onewire_rom_search_engine.sv]
// top level of the search rom decision engine for a four-line bus
//
//   channel  dir  payload                                   handshake
//   i_req    in   func, start_discrepancy, presence/read    valid/ready
//                 and complement bits per line
//   o_res    out  status, write_bits, rom_id,               valid/ready
//                 next_discrepancy
//   i_cfg    in   channel_mask (4 bits)                     valid/ready, ready always high
//
// one request per cycle sustained while o_res.ready is high; each request passes
// from acceptance through the input register, then through the decision
// logic into the result register. reset (synchronous, active low) clears the
// search state and sets the channel mask to line 0 only. a stalled result
// holds the state and the input register, and i_req.ready drops once both
// registers are full.
module onewire_rom_search_engine #(
    parameter int ID_BITS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ors_stream_if.sink    i_req,
    ors_stream_if.source  o_res,
    ors_stream_if.sink    i_cfg
);
    import ors_pkg::*;

    t_cfg  r_mask;
    logic  take;
    logic  item_valid;
    t_item item;

    // channel mask register, written whenever a configuration write arrives
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= t_cfg'(1);
        end else if (i_cfg.valid) begin
            r_mask <= i_cfg.payload;
        end
    end

    // input register
    ors_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    // decision and result register
    ors_core #(
        .ID_BITS (ID_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (item_valid),
        .i_item  (item),
        .i_mask  (r_mask),
        .o_take  (take),
        .o_res   (o_res)
    );

endmodule
